// ===== hw/rtl/rzsa_pkg.sv =====
// rzsa_pkg: shared types and constants for the rotate/zoom source address unit.
// Holds register index codes and fixed field widths. No dependencies.
`default_nettype none

package rzsa_pkg;

    // Configuration register index
    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_COS_OVER_ZOOM    = 3'd0;
    localparam t_reg_idx REG_SIN_OVER_ZOOM    = 3'd1;
    localparam t_reg_idx REG_SRC_WIDTH        = 3'd2;
    localparam t_reg_idx REG_SRC_HEIGHT       = 3'd3;
    localparam t_reg_idx REG_DEST_HALF_WIDTH  = 3'd4;
    localparam t_reg_idx REG_DEST_HALF_HEIGHT = 3'd5;
    localparam t_reg_idx REG_ROW_PITCH        = 3'd6;
    localparam t_reg_idx REG_BYTES_PER_PIXEL  = 3'd7;

    // Field widths
    localparam int COEF_W  = 22;  // cos/sin over zoom
    localparam int DIM_W   = 13;  // source width/height
    localparam int HALF_W  = 12;  // destination half sizes
    localparam int PITCH_W = 15;
    localparam int BPP_W   = 3;
    localparam int DEST_W  = 12;  // dest_x / dest_y
    localparam int COORD_W = 19;  // src_x / src_y
    localparam int ADDR_W  = 26;
    localparam int CFG_DW  = 22;  // widest register

    localparam int DELTA_W = DEST_W + 1;        // signed dest minus half size
    localparam int PROD_W  = COEF_W + DELTA_W;  // one coefficient product
    localparam int SUM_W   = PROD_W + 1;        // rotated sum

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    localparam logic signed [31:0] COORD_MAX = 32'sd262143;
    localparam logic signed [31:0] COORD_MIN = -32'sd262144;

    // Largest value the source size register can hold
    localparam int DIM_REG_MAX = 8191;

endpackage

`default_nettype wire

// ===== hw/rtl/rotate_zoom_source_address_unit.sv =====
// Source address generator for nearest-neighbor rotation with zoom.
// Depends on rzsa_pkg (register codes, field widths).
//
// Usage:
//   Slave stream s_axis_* carries one destination pixel per request
//   (dest_x, dest_y). Master stream m_axis_* returns one request per input:
//   the mapped source column and row (saturated to 19 bits), an inside flag
//   on tuser, and the source byte address (zero when the point is outside).
//   The configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index,
//   i_cfg_data) writes the eight registers; it is always ready and should
//   be written only while the pipeline is empty.
//   The pipe takes one request per cycle; the seven register stages (delta,
//   products, rotated sum, truncation, centering, bounds test with address
//   products, address sum) each carry a valid bit.
//   A stall on m_axis_tready holds the last stage; earlier stages keep
//   filling bubbles, and s_axis_tready drops only when every stage is full.
//   Synchronous active-low reset empties the pipe and loads the register
//   defaults (unit scale, no rotation, 1x1 source, pitch 1, 1 byte/pixel).
`default_nettype none

module rotate_zoom_source_address_unit #(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration write channel
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  rzsa_pkg::t_reg_idx                   i_cfg_index,
    input  wire  [rzsa_pkg::CFG_DW-1:0]          i_cfg_data,
    // input stream
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire  [rzsa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // dest_x[11:0], dest_y[23:12]
    // output stream
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    output logic [rzsa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // src_x[18:0], src_y[37:19],
                                                                // byte_address[63:38]
    output logic                                 m_axis_tuser   // inside_res[0]
);

    localparam int NS    = 7;
    localparam int T_W   = rzsa_pkg::SUM_W - FRAC_BITS;
    localparam int BX_W  = ((T_W > rzsa_pkg::DIM_W) ? T_W : rzsa_pkg::DIM_W) + 1;
    localparam int CLAMP = (MAX_DIM > rzsa_pkg::DIM_REG_MAX) ? rzsa_pkg::DIM_REG_MAX : MAX_DIM;
    localparam logic [rzsa_pkg::DIM_W-1:0] DIM_LIMIT = rzsa_pkg::DIM_W'(CLAMP);
    localparam logic [rzsa_pkg::SUM_W-1:0] TRUNC_BIAS =
        rzsa_pkg::SUM_W'((64'd1 << FRAC_BITS) - 64'd1);

    localparam int DW = rzsa_pkg::DELTA_W;
    localparam int PW = rzsa_pkg::PROD_W;
    localparam int SW = rzsa_pkg::SUM_W;
    localparam int CW = rzsa_pkg::COORD_W;
    localparam int AW = rzsa_pkg::ADDR_W;
    localparam int MW = rzsa_pkg::DIM_W;

    // ---------------- configuration registers ----------------
    logic signed [rzsa_pkg::COEF_W-1:0]  r_cos;
    logic signed [rzsa_pkg::COEF_W-1:0]  r_sin;
    logic        [MW-1:0]                r_src_w;
    logic        [MW-1:0]                r_src_h;
    logic        [rzsa_pkg::HALF_W-1:0]  r_dhw;
    logic        [rzsa_pkg::HALF_W-1:0]  r_dhh;
    logic        [rzsa_pkg::PITCH_W-1:0] r_pitch;
    logic        [rzsa_pkg::BPP_W-1:0]   r_bpp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos   <= rzsa_pkg::COEF_W'(65536);
            r_sin   <= '0;
            r_src_w <= MW'(1);
            r_src_h <= MW'(1);
            r_dhw   <= '0;
            r_dhh   <= '0;
            r_pitch <= rzsa_pkg::PITCH_W'(1);
            r_bpp   <= rzsa_pkg::BPP_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rzsa_pkg::REG_COS_OVER_ZOOM:    r_cos   <= i_cfg_data[rzsa_pkg::COEF_W-1:0];
                rzsa_pkg::REG_SIN_OVER_ZOOM:    r_sin   <= i_cfg_data[rzsa_pkg::COEF_W-1:0];
                rzsa_pkg::REG_SRC_WIDTH:        r_src_w <= i_cfg_data[MW-1:0];
                rzsa_pkg::REG_SRC_HEIGHT:       r_src_h <= i_cfg_data[MW-1:0];
                rzsa_pkg::REG_DEST_HALF_WIDTH:  r_dhw   <= i_cfg_data[rzsa_pkg::HALF_W-1:0];
                rzsa_pkg::REG_DEST_HALF_HEIGHT: r_dhh   <= i_cfg_data[rzsa_pkg::HALF_W-1:0];
                rzsa_pkg::REG_ROW_PITCH:        r_pitch <= i_cfg_data[rzsa_pkg::PITCH_W-1:0];
                rzsa_pkg::REG_BYTES_PER_PIXEL:  r_bpp   <= i_cfg_data[rzsa_pkg::BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped source size, to be kept stable by the user while requests are in flight; the block does not enforce it
    logic [MW-1:0] w_clamped;
    logic [MW-1:0] h_clamped;
    assign w_clamped = (r_src_w > DIM_LIMIT) ? DIM_LIMIT : r_src_w;
    assign h_clamped = (r_src_h > DIM_LIMIT) ? DIM_LIMIT : r_src_h;

    // ---------------- pipeline control ----------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- datapath ----------------
    // stage 0: deltas from destination center
    logic signed [DW-1:0] n_dx, n_dy;
    logic signed [DW-1:0] r_dx, r_dy;
    assign n_dx = $signed({1'b0, s_axis_tdata[11:0]})  - $signed({1'b0, r_dhw});
    assign n_dy = $signed({1'b0, s_axis_tdata[23:12]}) - $signed({1'b0, r_dhh});

    // stage 1: four coefficient products
    logic signed [PW-1:0] r_cdx, r_sdy, r_cdy, r_sdx;
    // stage 2: rotated sums
    logic signed [SW-1:0] r_sx, r_sy;
    // stage 3: truncation toward zero
    logic signed [SW-1:0] n_bsx, n_bsy;
    logic signed [T_W-1:0] r_tx, r_ty;
    // stage 4: add source center
    logic signed [BX_W-1:0] n_bx, n_by;
    logic signed [BX_W-1:0] r_bx, r_by;
    // stage 5: bounds, saturation, address products
    logic signed [31:0] bx32, by32;
    logic               n_inside;
    logic [CW-1:0]      n_satx, n_saty;
    logic               r_inside5;
    logic [CW-1:0]      r_satx5, r_saty5;
    logic [AW-1:0]      r_prow, r_pcol;
    // stage 6: output
    logic               r_inside6;
    logic [CW-1:0]      r_satx6, r_saty6;
    logic [AW-1:0]      r_addr;

    assign n_bsx = r_sx + (r_sx[SW-1] ? $signed(TRUNC_BIAS) : $signed(SW'(0)));
    assign n_bsy = r_sy + (r_sy[SW-1] ? $signed(TRUNC_BIAS) : $signed(SW'(0)));

    assign n_bx = BX_W'(r_tx) + $signed(BX_W'({1'b0, w_clamped[MW-1:1]}));
    assign n_by = BX_W'(r_ty) + $signed(BX_W'({1'b0, h_clamped[MW-1:1]}));

    always_comb begin
        bx32 = 32'(r_bx);
        by32 = 32'(r_by);
        n_inside = (bx32 >= 32'sd0) && (bx32 < $signed({19'd0, w_clamped}))
                && (by32 >= 32'sd0) && (by32 < $signed({19'd0, h_clamped}));
        if (bx32 > rzsa_pkg::COORD_MAX)      n_satx = CW'(rzsa_pkg::COORD_MAX);
        else if (bx32 < rzsa_pkg::COORD_MIN) n_satx = CW'(rzsa_pkg::COORD_MIN);
        else                                 n_satx = bx32[CW-1:0];
        if (by32 > rzsa_pkg::COORD_MAX)      n_saty = CW'(rzsa_pkg::COORD_MAX);
        else if (by32 < rzsa_pkg::COORD_MIN) n_saty = CW'(rzsa_pkg::COORD_MIN);
        else                                 n_saty = by32[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (en[1]) begin
            r_cdx <= r_cos * r_dx;
            r_sdy <= r_sin * r_dy;
            r_cdy <= r_cos * r_dy;
            r_sdx <= r_sin * r_dx;
        end
        if (en[2]) begin
            r_sx <= SW'(r_cdx) + SW'(r_sdy);
            r_sy <= SW'(r_cdy) - SW'(r_sdx);
        end
        if (en[3]) begin
            r_tx <= n_bsx[SW-1:FRAC_BITS];
            r_ty <= n_bsy[SW-1:FRAC_BITS];
        end
        if (en[4]) begin
            r_bx <= n_bx;
            r_by <= n_by;
        end
        if (en[5]) begin
            r_inside5 <= n_inside;
            r_satx5   <= n_satx;
            r_saty5   <= n_saty;
            // only used when inside, where row and column fit the size register
            r_prow    <= AW'(r_by[MW-1:0] * r_pitch);
            r_pcol    <= AW'(r_bx[MW-1:0] * r_bpp);
        end
        if (en[6]) begin
            r_inside6 <= r_inside5;
            r_satx6   <= r_satx5;
            r_saty6   <= r_saty5;
            r_addr    <= r_inside5 ? AW'(r_prow + r_pcol) : '0;
        end
    end

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {r_addr, r_saty6, r_satx6};
    assign m_axis_tuser  = r_inside6;

    // ---------------- assertions ----------------
    a_outside_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:38] == '0)
        else $error("outside point carries a nonzero byte address");

    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[18] && !m_axis_tdata[37])
        else $error("inside point has a negative source coordinate");

    a_ready_when_tail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NS-1] |-> s_axis_tready)
        else $error("input stalled while the last stage is empty");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-2] && !en[NS-2] |=> r_vld[NS-2] && $stable(r_satx5))
        else $error("stalled stage lost its request");

endmodule

`default_nettype wire

// ===== test/rotate_zoom_source_address_unit_test.sv =====
// Self-checking bench for rotate_zoom_source_address_unit: a directed probe table, then
// random geometries and destination pixels, compared against an in-bench address map or
// against results typed in by hand. Depends on rzsa_pkg and the unit itself.
`timescale 1ns / 1ps

module rotate_zoom_source_address_unit_test;

    localparam int MAX_DIM      = 4096;
    localparam int FRAC_BITS    = 16;
    localparam int PIPE_LATENCY = 7;
    localparam int N_REGS       = 8;
    localparam int RANDOM_PHASES    = 12;
    localparam int POINTS_PER_PHASE = 86;

    typedef struct packed {
        logic signed [rzsa_pkg::COORD_W-1:0] sx;
        logic signed [rzsa_pkg::COORD_W-1:0] sy;
        logic                                in_bounds;
        logic [rzsa_pkg::ADDR_W-1:0]         addr;
    } t_src_point;

    // a request whose result is typed in by hand, or left to the address map
    typedef struct packed {
        logic       pinned;
        t_src_point want;
    } t_pinned_result;

    typedef struct {
        int geom;
        int x;
        int y;
        bit pinned;
        int sx;
        int sy;
        bit in_bounds;
        int addr;
    } t_probe;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    rzsa_pkg::t_reg_idx               i_cfg_index = rzsa_pkg::REG_COS_OVER_ZOOM;
    logic [rzsa_pkg::CFG_DW-1:0]      i_cfg_data = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rzsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // dest_x[11:0], dest_y[23:12]
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [rzsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // src_x[18:0], src_y[37:19],
                                                           // byte_address[63:38]
    logic                             m_axis_tuser;        // inside_res[0]

    rotate_zoom_source_address_unit #(
        .MAX_DIM  (MAX_DIM),
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // mirrored register file, reset values
    logic signed [rzsa_pkg::COEF_W-1:0] coef_cos = 22'sd65536;
    logic signed [rzsa_pkg::COEF_W-1:0] coef_sin = '0;
    logic [rzsa_pkg::DIM_W-1:0]         src_w = 13'd1;
    logic [rzsa_pkg::DIM_W-1:0]         src_h = 13'd1;
    logic [rzsa_pkg::HALF_W-1:0]        half_w = '0;
    logic [rzsa_pkg::HALF_W-1:0]        half_h = '0;
    logic [rzsa_pkg::PITCH_W-1:0]       pitch = 15'd1;
    logic [rzsa_pkg::BPP_W-1:0]         bpp = 3'd1;

    logic [rzsa_pkg::CFG_DW-1:0] next_bank [N_REGS];

    t_src_point     expected_sources [$];
    t_pinned_result typed_ahead [$];
    int             mismatch_count = 0;
    int             results_seen = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;

    t_probe probes [20] = '{
        // reset geometry: unit scale, 1x1 source
        '{0, 0, 0, 1, 0, 0, 1, 0},
        '{0, 1, 0, 1, 1, 0, 0, 0},
        '{0, 4095, 4095, 1, 4095, 4095, 0, 0},
        '{0, 0, 4095, 0, 0, 0, 0, 0},
        // oversized source clamped, pitch 16384 and 4 bytes per pixel
        '{1, 0, 0, 1, 0, 0, 1, 0},
        '{1, 4095, 4095, 1, 4095, 4095, 1, 67108860},
        '{1, 2048, 1000, 0, 0, 0, 0, 0},
        // empty source
        '{2, 0, 0, 1, 0, 0, 0, 0},
        '{2, 5, 7, 1, 5, 7, 0, 0},
        // extreme coefficients: saturation and address wrap
        '{3, 0, 0, 1, 2048, 262143, 0, 0},
        '{3, 4095, 4095, 1, 2048, 2048, 1, 12288},
        '{3, 4094, 4095, 0, 0, 0, 0, 0},
        // half scale: truncation toward zero, zero bytes per pixel
        '{4, 9, 9, 1, 32, 32, 1, 2048},
        '{4, 8, 8, 0, 0, 0, 0, 0},
        '{4, 11, 11, 0, 0, 0, 0, 0},
        '{4, 0, 0, 0, 0, 0, 0, 0},
        // quarter turn, negative rows
        '{5, 0, 0, 0, 0, 0, 0, 0},
        '{5, 40, 0, 0, 0, 0, 0, 0},
        '{5, 4095, 0, 0, 0, 0, 0, 0},
        '{5, 20, 20, 0, 0, 0, 0, 0}
    };

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_src_point map_to_source(logic [rzsa_pkg::DEST_W-1:0] x,
                                                 logic [rzsa_pkg::DEST_W-1:0] y);
        t_src_point r;
        longint dx, dy, w, h, sx, sy, bx, by, a;
        dx = longint'(x) - longint'(half_w);
        dy = longint'(y) - longint'(half_h);
        w = (src_w > MAX_DIM) ? MAX_DIM : longint'(src_w);
        h = (src_h > MAX_DIM) ? MAX_DIM : longint'(src_h);
        sx = longint'(coef_cos) * dx + longint'(coef_sin) * dy;
        sy = longint'(coef_cos) * dy - longint'(coef_sin) * dx;
        // signed division truncates toward zero
        bx = w / 2 + sx / (longint'(1) << FRAC_BITS);
        by = h / 2 + sy / (longint'(1) << FRAC_BITS);
        r.in_bounds = (bx >= 0 && bx < w && by >= 0 && by < h);
        a = r.in_bounds ? by * longint'(pitch) + bx * longint'(bpp) : 0;
        r.addr = a[rzsa_pkg::ADDR_W-1:0];
        // bounds use the raw value, the port the saturated one
        if (bx > rzsa_pkg::COORD_MAX) bx = rzsa_pkg::COORD_MAX;
        if (bx < rzsa_pkg::COORD_MIN) bx = rzsa_pkg::COORD_MIN;
        if (by > rzsa_pkg::COORD_MAX) by = rzsa_pkg::COORD_MAX;
        if (by < rzsa_pkg::COORD_MIN) by = rzsa_pkg::COORD_MIN;
        r.sx = bx[rzsa_pkg::COORD_W-1:0];
        r.sy = by[rzsa_pkg::COORD_W-1:0];
        return r;
    endfunction

    // receiver: drop tready at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : result_monitor
        t_src_point got;
        t_src_point want;
        t_pinned_result pin;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pin = (typed_ahead.size() > 0) ? typed_ahead.pop_front() : '0;
                if (pin.pinned) begin
                    expected_sources.push_back(pin.want);
                end else begin
                    expected_sources.push_back(map_to_source(s_axis_tdata[11:0],
                                                             s_axis_tdata[23:12]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.sx = m_axis_tdata[18:0];
                got.sy = m_axis_tdata[37:19];
                got.addr = m_axis_tdata[63:38];
                got.in_bounds = m_axis_tuser;
                if (expected_sources.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with no request pending", results_seen);
                end else begin
                    want = expected_sources.pop_front();
                    if (got.sx !== want.sx || got.sy !== want.sy ||
                        got.in_bounds !== want.in_bounds || got.addr !== want.addr) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result %0d: expected x=%0d y=%0d in=%0b addr=%0d, ",
                                      "got x=%0d y=%0d in=%0b addr=%0d"}, results_seen,
                                     want.sx, want.sy, want.in_bounds, want.addr,
                                     got.sx, got.sy, got.in_bounds, got.addr);
                    end
                end
                results_seen++;
            end
        end
    end

    task automatic write_reg(rzsa_pkg::t_reg_idx idx, logic [rzsa_pkg::CFG_DW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rzsa_pkg::REG_COS_OVER_ZOOM:    coef_cos = value[rzsa_pkg::COEF_W-1:0];
            rzsa_pkg::REG_SIN_OVER_ZOOM:    coef_sin = value[rzsa_pkg::COEF_W-1:0];
            rzsa_pkg::REG_SRC_WIDTH:        src_w = value[rzsa_pkg::DIM_W-1:0];
            rzsa_pkg::REG_SRC_HEIGHT:       src_h = value[rzsa_pkg::DIM_W-1:0];
            rzsa_pkg::REG_DEST_HALF_WIDTH:  half_w = value[rzsa_pkg::HALF_W-1:0];
            rzsa_pkg::REG_DEST_HALF_HEIGHT: half_h = value[rzsa_pkg::HALF_W-1:0];
            rzsa_pkg::REG_ROW_PITCH:        pitch = value[rzsa_pkg::PITCH_W-1:0];
            rzsa_pkg::REG_BYTES_PER_PIXEL:  bpp = value[rzsa_pkg::BPP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_bank();
        for (int r = 0; r < N_REGS; r++)
            write_reg(rzsa_pkg::t_reg_idx'(r), next_bank[r]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [rzsa_pkg::IN_TDATA_W-1:0] pixel, t_pinned_result pin);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        typed_ahead.push_back(pin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pixel;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold until the pipe is empty, then let it settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_sources.size() != 0 || typed_ahead.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    function automatic void set_directed_bank(int g);
        next_bank[rzsa_pkg::REG_COS_OVER_ZOOM] = 22'd65536;
        next_bank[rzsa_pkg::REG_SIN_OVER_ZOOM] = '0;
        next_bank[rzsa_pkg::REG_SRC_WIDTH] = 22'd1;
        next_bank[rzsa_pkg::REG_SRC_HEIGHT] = 22'd1;
        next_bank[rzsa_pkg::REG_DEST_HALF_WIDTH] = '0;
        next_bank[rzsa_pkg::REG_DEST_HALF_HEIGHT] = '0;
        next_bank[rzsa_pkg::REG_ROW_PITCH] = 22'd1;
        next_bank[rzsa_pkg::REG_BYTES_PER_PIXEL] = 22'd1;
        case (g)
            1: begin
                next_bank[rzsa_pkg::REG_SRC_WIDTH] = 22'd8191;
                next_bank[rzsa_pkg::REG_SRC_HEIGHT] = 22'd8191;
                next_bank[rzsa_pkg::REG_DEST_HALF_WIDTH] = 22'd2048;
                next_bank[rzsa_pkg::REG_DEST_HALF_HEIGHT] = 22'd2048;
                next_bank[rzsa_pkg::REG_ROW_PITCH] = 22'd16384;
                next_bank[rzsa_pkg::REG_BYTES_PER_PIXEL] = 22'd4;
            end
            2: begin
                next_bank[rzsa_pkg::REG_SRC_WIDTH] = '0;
                next_bank[rzsa_pkg::REG_SRC_HEIGHT] = '0;
            end
            3: begin
                next_bank[rzsa_pkg::REG_COS_OVER_ZOOM] = 22'h200000;
                next_bank[rzsa_pkg::REG_SIN_OVER_ZOOM] = 22'h1FFFFF;
                next_bank[rzsa_pkg::REG_SRC_WIDTH] = 22'd4096;
                next_bank[rzsa_pkg::REG_SRC_HEIGHT] = 22'd4096;
                next_bank[rzsa_pkg::REG_DEST_HALF_WIDTH] = 22'd4095;
                next_bank[rzsa_pkg::REG_DEST_HALF_HEIGHT] = 22'd4095;
                next_bank[rzsa_pkg::REG_ROW_PITCH] = 22'd32767;
                next_bank[rzsa_pkg::REG_BYTES_PER_PIXEL] = 22'd7;
            end
            4: begin
                next_bank[rzsa_pkg::REG_COS_OVER_ZOOM] = 22'd32768;
                next_bank[rzsa_pkg::REG_SRC_WIDTH] = 22'd64;
                next_bank[rzsa_pkg::REG_SRC_HEIGHT] = 22'd64;
                next_bank[rzsa_pkg::REG_DEST_HALF_WIDTH] = 22'd10;
                next_bank[rzsa_pkg::REG_DEST_HALF_HEIGHT] = 22'd10;
                next_bank[rzsa_pkg::REG_ROW_PITCH] = 22'd64;
                next_bank[rzsa_pkg::REG_BYTES_PER_PIXEL] = '0;
            end
            5: begin
                next_bank[rzsa_pkg::REG_COS_OVER_ZOOM] = '0;
                next_bank[rzsa_pkg::REG_SIN_OVER_ZOOM] = 22'd65536;
                next_bank[rzsa_pkg::REG_SRC_WIDTH] = 22'd100;
                next_bank[rzsa_pkg::REG_SRC_HEIGHT] = 22'd50;
                next_bank[rzsa_pkg::REG_DEST_HALF_WIDTH] = 22'd20;
                next_bank[rzsa_pkg::REG_DEST_HALF_HEIGHT] = 22'd20;
                next_bank[rzsa_pkg::REG_ROW_PITCH] = 22'd300;
                next_bank[rzsa_pkg::REG_BYTES_PER_PIXEL] = 22'd5;
            end
            default: ;
        endcase
    endfunction

    function automatic void set_random_bank();
        int style, w, h, b;
        style = $urandom_range(0, 5);
        w = $urandom_range(1, 600);
        h = $urandom_range(1, 600);
        b = $urandom_range(1, 4);
        if (style <= 2) begin
            // plausible rotate/zoom: |coef| up to 2.0, modest sizes
            next_bank[rzsa_pkg::REG_COS_OVER_ZOOM] =
                22'(int'($urandom_range(0, 262144)) - 131072);
            next_bank[rzsa_pkg::REG_SIN_OVER_ZOOM] =
                22'(int'($urandom_range(0, 262144)) - 131072);
            next_bank[rzsa_pkg::REG_SRC_WIDTH] = 22'(w);
            next_bank[rzsa_pkg::REG_SRC_HEIGHT] = 22'(h);
            next_bank[rzsa_pkg::REG_DEST_HALF_WIDTH] = 22'($urandom_range(0, 700));
            next_bank[rzsa_pkg::REG_DEST_HALF_HEIGHT] = 22'($urandom_range(0, 700));
            next_bank[rzsa_pkg::REG_ROW_PITCH] = 22'(w * b + int'($urandom_range(0, 64)));
            next_bank[rzsa_pkg::REG_BYTES_PER_PIXEL] = 22'(b);
        end else if (style == 3) begin
            // raw words, upper bits beyond each register included
            for (int r = 0; r < N_REGS; r++)
                next_bank[r] = 22'($urandom());
        end else begin
            next_bank[rzsa_pkg::REG_COS_OVER_ZOOM] = 22'($urandom());
            next_bank[rzsa_pkg::REG_SIN_OVER_ZOOM] = 22'($urandom());
            next_bank[rzsa_pkg::REG_SRC_WIDTH] = 22'($urandom_range(2048, 8191));
            next_bank[rzsa_pkg::REG_SRC_HEIGHT] = 22'($urandom_range(2048, 8191));
            next_bank[rzsa_pkg::REG_DEST_HALF_WIDTH] = 22'($urandom_range(0, 4095));
            next_bank[rzsa_pkg::REG_DEST_HALF_HEIGHT] = 22'($urandom_range(0, 4095));
            next_bank[rzsa_pkg::REG_ROW_PITCH] = 22'($urandom_range(1, 32767));
            next_bank[rzsa_pkg::REG_BYTES_PER_PIXEL] = 22'($urandom_range(0, 7));
        end
    endfunction

    // mostly pixels around the destination center, some anywhere
    function automatic logic [rzsa_pkg::IN_TDATA_W-1:0] pick_pixel();
        int x, y, span;
        if ($urandom_range(0, 3) == 0)
            return rzsa_pkg::IN_TDATA_W'($urandom());
        span = $urandom_range(1, 700);
        x = int'(half_w) + int'($urandom_range(0, 2 * span)) - span;
        y = int'(half_h) + int'($urandom_range(0, 2 * span)) - span;
        x = (x < 0) ? 0 : (x > 4095) ? 4095 : x;
        y = (y < 0) ? 0 : (y > 4095) ? 4095 : y;
        return {12'(y), 12'(x)};
    endfunction

    initial begin
        int current_geom;
        t_pinned_result pin;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 34;
        recv_idle_pct = 85;
        current_geom = 0;
        foreach (probes[i]) begin
            if (probes[i].geom != current_geom) begin
                drain();
                set_directed_bank(probes[i].geom);
                apply_bank();
                current_geom = probes[i].geom;
            end
            pin.pinned = probes[i].pinned;
            pin.want.sx = 19'(probes[i].sx);
            pin.want.sy = 19'(probes[i].sy);
            pin.want.in_bounds = probes[i].in_bounds;
            pin.want.addr = 26'(probes[i].addr);
            send_pixel({12'(probes[i].y), 12'(probes[i].x)}, pin);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 34;
            end else if (phase == 2 * RANDOM_PHASES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            set_random_bank();
            apply_bank();
            for (int n = 0; n < POINTS_PER_PHASE; n++)
                send_pixel(pick_pixel(), '0);
        end

        drain();
        mismatch_count += expected_sources.size();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== rotate_zoom_source_address_unit.f =====
hw/rtl/rzsa_pkg.sv
hw/rtl/rotate_zoom_source_address_unit.sv
test/rotate_zoom_source_address_unit_test.sv
